>>> rtl/lbps_pkg.sv
// Shared types, codes and the blink step ROM for the LED blink pattern sequencer.
package lbps_pkg;

    localparam int unsigned CODE_W     = 3;
    localparam int unsigned ONESHOT_W  = 32;
    localparam int unsigned STEP_NUM_W = 5;
    localparam int unsigned STEP_MS_W  = 11;
    localparam int unsigned ROM_IDX_W  = 6;
    localparam int unsigned ROM_STEPS  = 37;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned MAX_STEP_MS = 1720;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SET_STABLE = 2'd1,
        FUNC_ONESHOT    = 2'd2
    } func_t;

    localparam logic [CODE_W-1:0] PAT_OFF   = 3'd0;
    localparam logic [CODE_W-1:0] PAT_BOOT  = 3'd1;
    localparam logic [CODE_W-1:0] PAT_AP    = 3'd2;
    localparam logic [CODE_W-1:0] PAT_STA   = 3'd3;
    localparam logic [CODE_W-1:0] PAT_OTA   = 3'd4;
    localparam logic [CODE_W-1:0] PAT_ERROR = 3'd5;
    localparam logic [CODE_W-1:0] PAT_PANIC = 3'd6;
    localparam logic [CODE_W-1:0] NUM_PATTERNS = 3'd7;

    typedef struct packed {
        logic [1:0]           func;
        logic [CODE_W-1:0]    pattern_code;
        logic [ONESHOT_W-1:0] oneshot_ms;
    } item_t;

    typedef struct packed {
        logic              pin_level;
        logic              led_lit;
        logic [CODE_W-1:0] shown_pattern;
        logic              oneshot_running;
    } result_t;

    // handshake between the pipeline stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

    function automatic logic [ROM_IDX_W-1:0] pat_first(input logic [CODE_W-1:0] code);
        logic [ROM_IDX_W-1:0] r;
        unique case (code)
            PAT_OFF:   r = 6'd0;
            PAT_BOOT:  r = 6'd1;
            PAT_AP:    r = 6'd2;
            PAT_STA:   r = 6'd4;
            PAT_OTA:   r = 6'd8;
            PAT_ERROR: r = 6'd10;
            PAT_PANIC: r = 6'd16;
            default:   r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [STEP_NUM_W-1:0] pat_len(input logic [CODE_W-1:0] code);
        logic [STEP_NUM_W-1:0] r;
        unique case (code)
            PAT_OFF:   r = 5'd1;
            PAT_BOOT:  r = 5'd1;
            PAT_AP:    r = 5'd2;
            PAT_STA:   r = 5'd4;
            PAT_OTA:   r = 5'd2;
            PAT_ERROR: r = 5'd6;
            PAT_PANIC: r = 5'd21;
            default:   r = 5'd1;
        endcase
        return r;
    endfunction

    function automatic logic rom_level(input logic [ROM_IDX_W-1:0] idx);
        logic r;
        unique case (idx)
            6'd1, 6'd2, 6'd4, 6'd6, 6'd8, 6'd10, 6'd12, 6'd14,
            6'd16, 6'd18, 6'd20, 6'd23, 6'd25, 6'd27,
            6'd30, 6'd32, 6'd34: r = 1'b1;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [STEP_MS_W-1:0] rom_ms(input logic [ROM_IDX_W-1:0] idx);
        logic [STEP_MS_W-1:0] r;
        unique case (idx)
            6'd0:  r = 11'd200;
            6'd1:  r = 11'd200;
            6'd2:  r = 11'd500;
            6'd3:  r = 11'd500;
            6'd4:  r = 11'd80;
            6'd5:  r = 11'd120;
            6'd6:  r = 11'd80;
            6'd7:  r = 11'd1720;
            6'd8:  r = 11'd100;
            6'd9:  r = 11'd100;
            6'd10: r = 11'd600;
            6'd11: r = 11'd150;
            6'd12: r = 11'd150;
            6'd13: r = 11'd150;
            6'd14: r = 11'd600;
            6'd15: r = 11'd800;
            6'd16: r = 11'd120;
            6'd17: r = 11'd180;
            6'd18: r = 11'd120;
            6'd19: r = 11'd180;
            6'd20: r = 11'd120;
            6'd21: r = 11'd180;
            6'd22: r = 11'd200;
            6'd23: r = 11'd360;
            6'd24: r = 11'd180;
            6'd25: r = 11'd360;
            6'd26: r = 11'd180;
            6'd27: r = 11'd360;
            6'd28: r = 11'd180;
            6'd29: r = 11'd200;
            6'd30: r = 11'd120;
            6'd31: r = 11'd180;
            6'd32: r = 11'd120;
            6'd33: r = 11'd180;
            6'd34: r = 11'd120;
            6'd35: r = 11'd180;
            6'd36: r = 11'd800;
            default: r = 11'd200;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/lbps_in_stage.sv
// Input register stage: captures one word from the slave channel.
module lbps_in_stage
    import lbps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 advance,
    output stage_ctl_t           ctl,
    output item_t                item
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    logic  s_fire;

    assign s_axis_tready = !valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.func         <= s_axis_tuser;
            item_reg.pattern_code <= s_axis_tdata[CODE_W-1:0];
            item_reg.oneshot_ms   <= s_axis_tdata[CODE_W +: ONESHOT_W];
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign item        = item_reg;

endmodule

>>> rtl/lbps_core.sv
// Sequencer state and per-word update: tick, stable write, one-shot start.
module lbps_core
    import lbps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t ctl,
    input  item_t      item,
    input  logic       pin_invert,
    output result_t    result
);

    logic [CODE_W-1:0]     stable_code_reg,  stable_code_next;
    logic [CODE_W-1:0]     oneshot_code_reg, oneshot_code_next;
    logic [ONESHOT_W-1:0]  oneshot_left_reg, oneshot_left_next;
    logic [CODE_W-1:0]     playing_reg,      playing_next;
    logic [STEP_NUM_W-1:0] step_num_reg,     step_num_next;
    logic [STEP_MS_W-1:0]  step_left_reg,    step_left_next;
    logic                  lit_reg,          lit_next;

    logic                  fire;
    logic [CODE_W-1:0]     cur_code, sel_code, load_code;
    logic [STEP_NUM_W-1:0] load_step, step_inc;
    logic [ROM_IDX_W-1:0]  rom_idx_raw, rom_idx;
    logic                  boundary;

    assign fire = ctl.valid && ctl.advance;

    // step loading, used only by a tick with no step in progress
    always_comb begin
        cur_code    = (playing_reg < NUM_PATTERNS) ? playing_reg : PAT_OFF;
        boundary    = (step_num_reg == '0) || (step_num_reg >= pat_len(cur_code));
        sel_code    = (oneshot_left_reg != '0) ? oneshot_code_reg : stable_code_reg;
        if (sel_code >= NUM_PATTERNS) begin
            sel_code = PAT_OFF;
        end
        load_code   = boundary ? sel_code : cur_code;
        load_step   = boundary ? '0 : step_num_reg;
        rom_idx_raw = pat_first(load_code) + {1'b0, load_step};
        rom_idx     = (rom_idx_raw >= ROM_IDX_W'(ROM_STEPS)) ? '0 : rom_idx_raw;
        step_inc    = load_step + 1'b1;
        if (step_inc >= pat_len(load_code)) begin
            step_inc = '0;
        end
    end

    always_comb begin
        stable_code_next  = stable_code_reg;
        oneshot_code_next = oneshot_code_reg;
        oneshot_left_next = oneshot_left_reg;
        playing_next      = playing_reg;
        step_num_next     = step_num_reg;
        step_left_next    = step_left_reg;
        lit_next          = lit_reg;
        if (fire) begin
            unique case (item.func)
                FUNC_TICK: begin
                    if (step_left_reg == '0) begin
                        playing_next   = load_code;
                        step_num_next  = step_inc;
                        lit_next       = rom_level(rom_idx);
                        // ROM durations are never zero
                        step_left_next = rom_ms(rom_idx) - 1'b1;
                    end else begin
                        step_left_next = step_left_reg - 1'b1;
                    end
                    if (oneshot_left_reg != '0) begin
                        oneshot_left_next = oneshot_left_reg - 1'b1;
                    end
                end
                FUNC_SET_STABLE: begin
                    if (item.pattern_code < NUM_PATTERNS) begin
                        stable_code_next = item.pattern_code;
                    end
                end
                FUNC_ONESHOT: begin
                    if (item.pattern_code < NUM_PATTERNS) begin
                        oneshot_code_next = item.pattern_code;
                        oneshot_left_next = item.oneshot_ms;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_code_reg  <= PAT_BOOT;
            oneshot_code_reg <= PAT_OFF;
            oneshot_left_reg <= '0;
            playing_reg      <= PAT_OFF;
            step_num_reg     <= '0;
            step_left_reg    <= '0;
            lit_reg          <= 1'b0;
        end else begin
            stable_code_reg  <= stable_code_next;
            oneshot_code_reg <= oneshot_code_next;
            oneshot_left_reg <= oneshot_left_next;
            playing_reg      <= playing_next;
            step_num_reg     <= step_num_next;
            step_left_reg    <= step_left_next;
            lit_reg          <= lit_next;
        end
    end

    // result shows the state after this word
    assign result.pin_level       = lit_next ^ pin_invert;
    assign result.led_lit         = lit_next;
    assign result.shown_pattern   = playing_next;
    assign result.oneshot_running = (oneshot_left_next != '0);

    a_step_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_left_reg < STEP_MS_W'(MAX_STEP_MS))
        else $error("step countdown beyond longest ROM step");

    a_step_in_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        step_num_reg < pat_len(playing_reg))
        else $error("step number outside the playing pattern");

    a_codes_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        playing_reg != NUM_PATTERNS && stable_code_reg != NUM_PATTERNS
        && oneshot_code_reg != NUM_PATTERNS)
        else $error("ignored pattern code was stored");

    a_oneshot_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.func == FUNC_TICK && oneshot_left_reg != '0
        |=> oneshot_left_reg == $past(oneshot_left_reg) - 1'b1)
        else $error("one-shot time did not count down on a tick");

endmodule

>>> rtl/lbps_out_stage.sv
// Result register stage: holds one word for the master channel.
module lbps_out_stage
    import lbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  result_t               result,
    output logic                  advance,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign advance = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg.oneshot_running, result_reg.shown_pattern,
                            result_reg.led_lit, result_reg.pin_level};

endmodule

>>> rtl/led_blink_pattern_sequencer.sv
// Top level of the LED blink pattern sequencer.
//
// Slave channel: one word per command. tuser carries the command kind
// (tick, set stable pattern, start one-shot), tdata the pattern code and
// the one-shot duration in ms. Every accepted word, ignored ones too,
// yields exactly one word on the master channel with the pin level, the
// lit flag, the pattern being played and the one-shot running flag,
// showing the state after that command.
// cfg_wen/cfg_wdata write the pin_invert polarity bit; write it only idle.
// From slave acceptance to the earliest master acceptance a word passes
// one input register, then the state update and step ROM lookup into the
// result register. Throughput is one word per cycle while the master is
// ready, set by the state update loop. A stalled master holds its word and
// the input register still takes one more word before s_axis_tready drops.
// Reset (aresetn low, synchronous) empties both registers, selects the boot
// pattern as the stable one, clears one-shot time and leaves the LED off.
module led_blink_pattern_sequencer
    import lbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic                  cfg_wdata,      // pin_invert
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [2:0] pattern_code, [34:3] oneshot_ms
    input  logic [1:0]            s_axis_tuser,   // [1:0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] pin_level, [1] led_lit,
                                                  // [4:2] shown_pattern, [5] oneshot_running
);

    logic       pin_invert_reg;
    logic       advance;
    stage_ctl_t ctl;
    item_t      item;
    result_t    result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_invert_reg <= 1'b0;
        end else if (cfg_wen) begin
            pin_invert_reg <= cfg_wdata;
        end
    end

    lbps_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .ctl           (ctl),
        .item          (item)
    );

    lbps_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .item       (item),
        .pin_invert (pin_invert_reg),
        .result     (result)
    );

    lbps_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (ctl.valid && advance),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> sim/led_seq_checker.sv
`timescale 1ns / 1ps
// Checker for the LED blink sequencer: predicts each result word and compares it.
module led_seq_checker
    import lbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic                  cfg_wdata,      // pin_invert
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [2:0] pattern_code, [34:3] oneshot_ms
    input  logic [1:0]            s_axis_tuser,   // [1:0] func
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] pin_level, [1] led_lit,
                                                  // [4:2] shown_pattern, [5] oneshot_running
    output int                    mismatch_count,
    output int                    words_pending
);

    // predicted sequencer state
    logic                  polarity;
    logic [CODE_W-1:0]     base_pat;
    logic [CODE_W-1:0]     shot_pat;
    logic [ONESHOT_W-1:0]  shot_left;
    logic [CODE_W-1:0]     cur_pat;
    logic [STEP_NUM_W-1:0] next_step;
    logic [STEP_MS_W-1:0]  step_left;
    logic                  led_on;

    result_t expected_led_q[$];

    function automatic logic [STEP_NUM_W-1:0] pass_len(input logic [CODE_W-1:0] pat);
        case (pat)
            PAT_AP, PAT_OTA: return 5'd2;
            PAT_STA:         return 5'd4;
            PAT_ERROR:       return 5'd6;
            PAT_PANIC:       return 5'd21;
            default:         return 5'd1;
        endcase
    endfunction

    // {lit, duration in ms} of step n of a pattern
    function automatic logic [STEP_MS_W:0] blink_step(input logic [CODE_W-1:0] pat,
                                                      input logic [STEP_NUM_W-1:0] n);
        logic                 on;
        logic [STEP_MS_W-1:0] ms;
        int                   k;
        on = ~n[0];
        k  = n % 7;
        case (pat)
            PAT_BOOT: ms = 11'd200;
            PAT_AP:   ms = 11'd500;
            PAT_STA:  ms = n[0] ? ((n == 5'd3) ? 11'd1720 : 11'd120) : 11'd80;
            PAT_OTA:  ms = 11'd100;
            PAT_ERROR: begin
                case (n)
                    5'd0, 5'd4: ms = 11'd600;
                    5'd5:       ms = 11'd800;
                    default:    ms = 11'd150;
                endcase
            end
            PAT_PANIC: begin
                // three groups of seven: short, long, short flashes, each closed by a dark gap
                if (k == 6) begin
                    on = 1'b0;
                    ms = (n == 5'd20) ? 11'd800 : 11'd200;
                end else begin
                    on = ~k[0];
                    ms = k[0] ? 11'd180 : ((n / 7 == 1) ? 11'd360 : 11'd120);
                end
            end
            default: begin
                on = 1'b0;
                ms = 11'd200;
            end
        endcase
        return {on, ms};
    endfunction

    task automatic run_one_ms();
        logic [STEP_MS_W:0] st;
        if (step_left == '0) begin
            // a new pass picks the pattern; one-shot time is the value before this tick
            if (next_step == '0 || next_step >= pass_len(cur_pat)) begin
                next_step = '0;
                cur_pat   = (shot_left != '0) ? shot_pat : base_pat;
            end
            st        = blink_step(cur_pat, next_step);
            led_on    = st[STEP_MS_W];
            step_left = st[STEP_MS_W-1:0];
            next_step = next_step + 1'b1;
            if (next_step >= pass_len(cur_pat))
                next_step = '0;
        end
        if (step_left != '0)
            step_left = step_left - 1'b1;
        if (shot_left != '0)
            shot_left = shot_left - 1'b1;
    endtask

    task automatic take_command(input logic [1:0] f, input logic [CODE_W-1:0] code,
                                input logic [ONESHOT_W-1:0] ms);
        result_t w;
        case (f)
            FUNC_TICK: run_one_ms();
            FUNC_SET_STABLE: begin
                if (code < NUM_PATTERNS)
                    base_pat = code;
            end
            FUNC_ONESHOT: begin
                if (code < NUM_PATTERNS) begin
                    shot_pat  = code;
                    shot_left = ms;
                end
            end
            default: ;
        endcase
        w.pin_level       = led_on ^ polarity;
        w.led_lit         = led_on;
        w.shown_pattern   = cur_pat;
        w.oneshot_running = (shot_left != '0);
        expected_led_q.push_back(w);
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            polarity  = 1'b0;
            base_pat  = PAT_BOOT;
            shot_pat  = PAT_OFF;
            shot_left = '0;
            cur_pat   = PAT_OFF;
            next_step = '0;
            step_left = '0;
            led_on    = 1'b0;
            expected_led_q.delete();
        end else begin
            if (cfg_wen)
                polarity = cfg_wdata;
            // result side first, so a word accepted on this edge is never matched here
            if (m_axis_tvalid && m_axis_tready) begin
                got.pin_level       = m_axis_tdata[0];
                got.led_lit         = m_axis_tdata[1];
                got.shown_pattern   = m_axis_tdata[4:2];
                got.oneshot_running = m_axis_tdata[5];
                if (expected_led_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_led_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch, expected pin %0d lit %0d pattern %0d oneshot %0d,",
                                 $time, want.pin_level, want.led_lit, want.shown_pattern,
                                 want.oneshot_running);
                        $display("    got pin %0d lit %0d pattern %0d oneshot %0d",
                                 got.pin_level, got.led_lit, got.shown_pattern,
                                 got.oneshot_running);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_command(s_axis_tuser, s_axis_tdata[CODE_W-1:0],
                             s_axis_tdata[CODE_W+ONESHOT_W-1:CODE_W]);
        end
        words_pending = expected_led_q.size();
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the LED blink sequencer: clock, reset, stimulus and verdict.
module tb;
    import lbps_pkg::*;

    localparam int STALL_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 150;
    localparam int RANDOM_PER_PHASE = 400;

    localparam logic [1:0]        FUNC_NONE  = 2'd3;
    localparam logic [CODE_W-1:0] PAT_UNUSED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wen;
    logic                  cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [2:0] pattern_code, [34:3] oneshot_ms
    logic [1:0]            s_axis_tuser;   // [1:0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] pin_level, [1] led_lit,
                                           // [4:2] shown_pattern, [5] oneshot_running

    int fails;
    int pending;
    int tx_idle_pct = 32;
    int rx_idle_pct = 62;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    int quiet_cycles = 0;

    led_blink_pattern_sequencer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    led_seq_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (fails),
        .words_pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random back-pressure, plus one long hold so the block fills up
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken    = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [1:0] f, input logic [CODE_W-1:0] code,
                             input logic [ONESHOT_W-1:0] ms);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = f;
        s_axis_tdata  = {{(IN_DATA_W-CODE_W-ONESHOT_W){1'b0}}, ms, code};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // mostly ticks; commands favour the short patterns so passes end often
    task automatic send_random_word();
        int                   roll;
        logic [1:0]           f;
        logic [CODE_W-1:0]    code;
        logic [ONESHOT_W-1:0] ms;
        roll = $urandom_range(99);
        if (roll < 82)
            f = FUNC_TICK;
        else if (roll < 90)
            f = FUNC_SET_STABLE;
        else if (roll < 97)
            f = FUNC_ONESHOT;
        else
            f = FUNC_NONE;
        if ($urandom_range(9) < 7) begin
            case ($urandom_range(3))
                0:       code = PAT_OFF;
                1:       code = PAT_BOOT;
                2:       code = PAT_AP;
                default: code = PAT_OTA;
            endcase
        end else begin
            code = CODE_W'($urandom_range(7));
        end
        case ($urandom_range(9))
            5, 6, 7: ms = $urandom_range(40);
            8:       ms = $urandom;
            9:       ms = '1;
            default: ms = $urandom_range(1500);
        endcase
        send_word(f, code, ms);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_polarity(input logic v);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_wen   = 1'b0;
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_TICK;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: boundary after reset, ignored codes, zero and full one-shot times
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        send_word(FUNC_SET_STABLE, PAT_UNUSED, 32'd17);
        send_word(FUNC_NONE,       PAT_PANIC,  '1);
        send_word(FUNC_ONESHOT,    PAT_OTA,    '0);
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        send_word(FUNC_ONESHOT,    PAT_UNUSED, 32'd5);
        send_word(FUNC_ONESHOT,    PAT_PANIC,  '1);
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        send_word(FUNC_ONESHOT,    PAT_AP,     32'd1);
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        send_word(FUNC_SET_STABLE, PAT_PANIC,  '0);
        send_word(FUNC_SET_STABLE, PAT_ERROR,  '0);
        send_word(FUNC_SET_STABLE, PAT_OTA,    '0);
        send_word(FUNC_SET_STABLE, PAT_STA,    '0);
        send_word(FUNC_SET_STABLE, PAT_AP,     '0);
        send_word(FUNC_SET_STABLE, PAT_BOOT,   '0);
        send_word(FUNC_SET_STABLE, PAT_OFF,    '0);
        send_word(FUNC_ONESHOT,    PAT_OFF,    32'h8000_0000);
        send_word(FUNC_ONESHOT,    PAT_BOOT,   32'd3);
        send_word(FUNC_ONESHOT,    PAT_STA,    32'd250);
        send_word(FUNC_ONESHOT,    PAT_ERROR,  32'd2);
        send_word(FUNC_TICK,       PAT_UNUSED, '1);
        send_word(FUNC_TICK,       PAT_OFF,    '0);
        wait_for_results();

        write_polarity(1'b1);
        repeat (RANDOM_PER_PHASE) send_random_word();
        wait_for_results();

        write_polarity(1'b0);
        tx_idle_pct = 62;
        rx_idle_pct = 32;
        repeat (RANDOM_PER_PHASE) send_random_word();
        wait_for_results();

        write_polarity(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (RANDOM_PER_PHASE) send_random_word();
        wait_for_results();

        repeat (10) @(posedge aclk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/lbps_pkg.sv
rtl/lbps_in_stage.sv
rtl/lbps_core.sv
rtl/lbps_out_stage.sv
rtl/led_blink_pattern_sequencer.sv
sim/led_seq_checker.sv
sim/tb.sv
